### hw/rtl/msbbp_pkg.sv
// Shared types and constants for the MSB-first bit packer.
// No dependencies.
package msbbp_pkg;

  typedef enum logic [1:0] {
    OP_BIT1  = 2'd0,
    OP_BIT8  = 2'd1,
    OP_BIT32 = 2'd2,
    OP_FLUSH = 2'd3
  } op_t;

  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned VALUE_W   = 32;
  localparam int unsigned FILL_W    = 3;
  localparam int unsigned MAX_BYTES = 4;
  localparam int unsigned WIN_W     = VALUE_W + BYTE_W;

endpackage

### hw/rtl/msb_first_bit_packer_core.sv
// Latency: the first byte of an item shows on m_tdata the cycle after s accept.
// Throughput: one item per cycle when each item emits at most one byte and m_tready
// holds; an item that emits more bytes holds the input until the four-byte output
// buffer drains to its last byte (up to four bytes for a 32-bit append).
// Reset (rst, synchronous, active high) empties the output queue and the
// pending partial byte.
// Packs 1/8/32-bit appends into bytes MSB first; depends on msbbp_pkg.
module msb_first_bit_packer_core (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [msbbp_pkg::VALUE_W-1:0]    s_tdata,   // [31:0] value
  input  logic [1:0]                       s_tuser,   // [1:0] operation
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [msbbp_pkg::BYTE_W-1:0]     m_tdata,   // [7:0] out_byte
  output logic                             m_tlast    // last
);
  import msbbp_pkg::*;

  logic [BYTE_W-1:0]           partial_byte, partial_byte_next;
  logic [FILL_W-1:0]           filled_bits, filled_bits_next;
  logic [MAX_BYTES*BYTE_W-1:0] out_buf, out_buf_next;
  logic [2:0]                  out_cnt, out_cnt_next;

  op_t                         op;
  logic [WIN_W-1:0]            aligned;
  logic [WIN_W-1:0]            window;
  logic [5:0]                  total_bits;
  logic [2:0]                  num_bytes;
  logic                        in_fire, out_fire;

  assign op       = op_t'(s_tuser);
  assign s_tready = (out_cnt == 3'd0) || ((out_cnt == 3'd1) && m_tready);
  assign in_fire  = s_tvalid && s_tready;
  assign m_tvalid = (out_cnt != 3'd0);
  assign out_fire = m_tvalid && m_tready;
  assign m_tdata  = out_buf[MAX_BYTES*BYTE_W-1 -: BYTE_W];
  assign m_tlast  = (out_cnt == 3'd1);

  // Place the new bits at the top of the window, then slide them behind the
  // pending bits.
  always_comb begin
    unique case (op)
      OP_BIT1:  begin
        aligned    = {s_tdata[0], {(WIN_W-1){1'b0}}};
        total_bits = {3'b000, filled_bits} + 6'd1;
      end
      OP_BIT8:  begin
        aligned    = {s_tdata[BYTE_W-1:0], {VALUE_W{1'b0}}};
        total_bits = {3'b000, filled_bits} + 6'd8;
      end
      OP_BIT32: begin
        aligned    = {s_tdata, {BYTE_W{1'b0}}};
        total_bits = {3'b000, filled_bits} + 6'd32;
      end
      default:  begin
        aligned    = '0;
        total_bits = {3'b000, filled_bits};
      end
    endcase
    window    = {partial_byte, {VALUE_W{1'b0}}} | (aligned >> filled_bits);
    num_bytes = total_bits[5:3];
  end

  always_comb begin
    partial_byte_next = partial_byte;
    filled_bits_next  = filled_bits;
    out_buf_next      = out_buf;
    out_cnt_next      = out_cnt;
    if (out_fire) begin
      out_buf_next = {out_buf[MAX_BYTES*BYTE_W-BYTE_W-1:0], {BYTE_W{1'b0}}};
      out_cnt_next = out_cnt - 3'd1;
    end
    if (in_fire) begin
      if (op == OP_FLUSH) begin
        out_buf_next      = {partial_byte, {(MAX_BYTES-1)*BYTE_W{1'b0}}};
        out_cnt_next      = {2'b00, (filled_bits != '0)};
        partial_byte_next = '0;
        filled_bits_next  = '0;
      end else begin
        out_buf_next     = window[WIN_W-1 -: MAX_BYTES*BYTE_W];
        out_cnt_next     = num_bytes;
        filled_bits_next = total_bits[2:0];
        // keep the byte that follows the completed ones
        unique case (num_bytes)
          3'd0:    partial_byte_next = window[39:32];
          3'd1:    partial_byte_next = window[31:24];
          3'd2:    partial_byte_next = window[23:16];
          3'd3:    partial_byte_next = window[15:8];
          default: partial_byte_next = window[7:0];
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      partial_byte <= '0;
      filled_bits  <= '0;
      out_cnt      <= '0;
    end else begin
      partial_byte <= partial_byte_next;
      filled_bits  <= filled_bits_next;
      out_cnt      <= out_cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    out_buf <= out_buf_next;
  end

endmodule
